// ===== hw/rtl/dq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_pkg
// Types and codes shared by the double-ended queue controller and datapath.
// ----------------------------------------------------------------------------
package dq_pkg;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_DUMP       = 3'd4
  } dq_cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } dq_status_e;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] value_in;
  } dq_in_t;

  typedef struct packed {
    logic signed [31:0] value_out;
    logic [1:0]         status;
    logic               last;
  } dq_out_t;

  // Controller to datapath
  typedef struct packed {
    logic       wr_front;    // push at front: write slot, move front back
    logic       wr_back;     // push at back: write slot after tail
    logic       rd_front;    // pop front: read front slot, advance front
    logic       rd_back;     // pop back: read tail slot
    logic       dump_first;  // dump: read front slot
    logic       dump_next;   // dump: read following slot
    logic       load_rd;     // result register takes read data
    logic       load_imm;    // result register takes a status-only result
    dq_status_e imm_status;
  } dq_ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
    logic out_last;
  } dq_stat_t;

endpackage

// ===== hw/rtl/double_ended_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue of signed 32-bit values in a circular buffer.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o / in_data_i) takes one item: a
// command and a value. Push front/back and pop front/back each give one
// result item; a dump gives one result per stored value, front to back,
// with last set on the final one. Pop or dump on an empty queue and push
// on a full one give a single status-only result. Unused commands give no
// result.
// Timing: a push result is valid the cycle after the item is taken; a pop
// or the first dump value passes through the registered read of the slot
// memory and then the result register; each further dump value is read
// the same way once the previous one is taken. One item is in work at a
// time: in_stall_o stays high until its last result is taken.
// Reset empties the queue at once; slot contents are not cleared.
// While out_stall_i is high the result holds and in_stall_o stays high.
// ----------------------------------------------------------------------------
module double_ended_queue #(
  parameter int DEPTH = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  dq_pkg::dq_in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output dq_pkg::dq_out_t out_data_o
);

  dq_pkg::dq_ctl_t  ctl;
  dq_pkg::dq_stat_t stat;

  dq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .cmd_i       (in_data_i.cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .ctl_o       (ctl)
  );

  dq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .value_in_i (in_data_i.value_in),
    .stat_o     (stat),
    .out_data_o (out_data_o)
  );

endmodule

// ===== hw/rtl/dq_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_datapath
// Circular slot memory, front index, element count, dump walk and the
// result register.
// ----------------------------------------------------------------------------
module dq_datapath #(
  parameter int DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dq_pkg::dq_ctl_t    ctl_i,
  input  logic signed [31:0] value_in_i,
  output dq_pkg::dq_stat_t   stat_o,
  output dq_pkg::dq_out_t    out_data_o
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  logic [IW-1:0] front_q, front_d;
  logic [CW-1:0] count_q, count_d;
  logic [IW-1:0] dump_k_q, dump_k_d;
  logic          rd_last_q, rd_last_d;

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rdata_q;

  logic signed [31:0] value_q;
  logic [1:0]         status_q;
  logic               last_q;

  logic [IW-1:0] front_prev, front_next, back_addr, tail_addr, dnext_addr;
  logic [IW-1:0] waddr, raddr;
  logic          we, re;

  // Sum is below twice DEPTH, so one conditional subtract wraps it.
  function automatic logic [IW-1:0] wrap_idx(input logic [SW-1:0] s);
    logic [SW-1:0] t;
    t = (s >= SW'(DEPTH)) ? s - SW'(DEPTH) : s;
    return t[IW-1:0];
  endfunction

  always_comb begin
    front_prev = (front_q == '0) ? IW'(DEPTH - 1) : front_q - IW'(1);
    front_next = wrap_idx(SW'(front_q) + SW'(1));
    back_addr  = wrap_idx(SW'(front_q) + SW'(count_q));
    tail_addr  = wrap_idx(SW'(front_q) + SW'(count_q) - SW'(1));
    dnext_addr = wrap_idx(SW'(front_q) + SW'(dump_k_q) + SW'(1));
  end

  assign we    = ctl_i.wr_front | ctl_i.wr_back;
  assign waddr = ctl_i.wr_front ? front_prev : back_addr;
  assign re    = ctl_i.rd_front | ctl_i.rd_back | ctl_i.dump_first | ctl_i.dump_next;

  always_comb begin
    raddr = front_q;
    if (ctl_i.rd_back) begin
      raddr = tail_addr;
    end else if (ctl_i.dump_next) begin
      raddr = dnext_addr;
    end
  end

  always_comb begin
    front_d   = front_q;
    count_d   = count_q;
    dump_k_d  = dump_k_q;
    rd_last_d = rd_last_q;
    if (ctl_i.wr_front) begin
      front_d = front_prev;
    end else if (ctl_i.rd_front) begin
      front_d = front_next;
    end
    if (we) begin
      count_d = count_q + CW'(1);
    end else if (ctl_i.rd_front || ctl_i.rd_back) begin
      count_d = count_q - CW'(1);
    end
    if (ctl_i.rd_front || ctl_i.rd_back) begin
      rd_last_d = 1'b1;
    end else if (ctl_i.dump_first) begin
      dump_k_d  = '0;
      rd_last_d = (count_q == CW'(1));
    end else if (ctl_i.dump_next) begin
      dump_k_d  = dump_k_q + IW'(1);
      rd_last_d = (SW'(dump_k_q) + SW'(2) == SW'(count_q));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q   <= '0;
      count_q   <= '0;
      dump_k_q  <= '0;
      rd_last_q <= 1'b0;
    end else begin
      front_q   <= front_d;
      count_q   <= count_d;
      dump_k_q  <= dump_k_d;
      rd_last_q <= rd_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= value_in_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  // Result register: payload only, validity lives in the controller
  always_ff @(posedge clk_i) begin
    if (ctl_i.load_imm) begin
      value_q  <= '0;
      status_q <= ctl_i.imm_status;
      last_q   <= 1'b1;
    end else if (ctl_i.load_rd) begin
      value_q  <= rdata_q;
      status_q <= dq_pkg::ST_OK;
      last_q   <= rd_last_q;
    end
  end

  assign stat_o.empty    = (count_q == '0);
  assign stat_o.full     = (count_q == CW'(DEPTH));
  assign stat_o.out_last = last_q;

  assign out_data_o.value_out = value_q;
  assign out_data_o.status    = status_q;
  assign out_data_o.last      = last_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("element count above capacity");

  a_front_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    SW'(front_q) < SW'(DEPTH))
    else $error("front index out of range");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.wr_front || ctl_i.wr_back) |-> !stat_o.full)
    else $error("push issued on a full queue");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.rd_front || ctl_i.rd_back) |=> count_q == $past(count_q) - CW'(1))
    else $error("pop did not reduce the count");
`endif

endmodule

// ===== hw/rtl/dq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_ctrl
// Sequencer for the double-ended queue: decodes each item, drives the
// datapath and holds the result handshake.
// ----------------------------------------------------------------------------
module dq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [2:0]       cmd_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  dq_pkg::dq_stat_t stat_i,
  output dq_pkg::dq_ctl_t  ctl_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_OUT  = 3'b100
  } dq_state_e;

  dq_state_e state_q, state_d;

  always_comb begin
    state_d          = state_q;
    ctl_o            = '0;
    ctl_o.imm_status = dq_pkg::ST_OK;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (cmd_i)
            dq_pkg::CMD_PUSH_FRONT, dq_pkg::CMD_PUSH_BACK: begin
              ctl_o.load_imm   = 1'b1;
              state_d          = S_OUT;
              if (stat_i.full) begin
                ctl_o.imm_status = dq_pkg::ST_FULL;
              end else begin
                ctl_o.wr_front = (cmd_i == dq_pkg::CMD_PUSH_FRONT);
                ctl_o.wr_back  = (cmd_i == dq_pkg::CMD_PUSH_BACK);
              end
            end
            dq_pkg::CMD_POP_FRONT, dq_pkg::CMD_POP_BACK, dq_pkg::CMD_DUMP: begin
              if (stat_i.empty) begin
                ctl_o.load_imm   = 1'b1;
                ctl_o.imm_status = dq_pkg::ST_EMPTY;
                state_d          = S_OUT;
              end else begin
                ctl_o.rd_front   = (cmd_i == dq_pkg::CMD_POP_FRONT);
                ctl_o.rd_back    = (cmd_i == dq_pkg::CMD_POP_BACK);
                ctl_o.dump_first = (cmd_i == dq_pkg::CMD_DUMP);
                state_d          = S_READ;
              end
            end
            default: ; // unused codes are swallowed without a result
          endcase
        end
      end
      S_READ: begin
        ctl_o.load_rd = 1'b1;
        state_d       = S_OUT;
      end
      S_OUT: begin
        if (!out_stall_i) begin
          if (stat_i.out_last) begin
            state_d = S_IDLE;
          end else begin
            ctl_o.dump_next = 1'b1;
            state_d         = S_READ;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

`ifndef SYNTHESIS
  a_wr_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_o.wr_front || ctl_o.wr_back || ctl_o.rd_front || ctl_o.rd_back)
      |-> (state_q == S_IDLE))
    else $error("queue update outside idle");
`endif

endmodule

// ===== test/tb_double_ended_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_double_ended_queue
// Self-checking bench for the double-ended queue: directed corner items, then
// random push/pop/dump traffic in fill, drain and balanced runs, checked item
// by item against a behavioural queue model under sender and receiver stalls.
// ----------------------------------------------------------------------------
module tb_double_ended_queue;
  import dq_pkg::*;

  localparam int         DEPTH            = 16;
  localparam int         CYCLE_LIMIT      = 200000;
  localparam int         SETTLE_CYCLES    = 40;
  localparam int         PHASE_ITEMS      = 30;
  localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;

  logic    clk_i       = 1'b0;
  logic    rst_ni      = 1'b0;
  logic    in_valid_i  = 1'b0;
  logic    in_stall_o;
  dq_in_t  in_data_i   = '0;
  logic    out_valid_o;
  logic    out_stall_i = 1'b0;
  dq_out_t out_data_o;

  int idle_pct  = 0;
  int stall_pct = 0;
  int cycle_count = 0;

  // Behavioural copy of the ring buffer plus the results still owed
  class dq_scoreboard;
    logic signed [31:0] slots [DEPTH];
    int unsigned        front;
    int unsigned        count;
    dq_out_t            owed_q [$];
    int unsigned        failures;

    function new();
      front    = 0;
      count    = 0;
      failures = 0;
    endfunction

    function void owe(logic signed [31:0] value, dq_status_e status, logic last);
      dq_out_t r;
      r.value_out = value;
      r.status    = status;
      r.last      = last;
      owed_q.push_back(r);
    endfunction

    function void note_item(dq_in_t it);
      int unsigned k;
      case (it.cmd)
        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
          if (count == DEPTH) begin
            owe('0, ST_FULL, 1'b1);
          end else begin
            if (it.cmd == CMD_PUSH_FRONT) begin
              front = (front + DEPTH - 1) % DEPTH;
              slots[front] = it.value_in;
            end else begin
              slots[(front + count) % DEPTH] = it.value_in;
            end
            count++;
            owe('0, ST_OK, 1'b1);
          end
        end
        CMD_POP_FRONT, CMD_POP_BACK: begin
          if (count == 0) begin
            owe('0, ST_EMPTY, 1'b1);
          end else if (it.cmd == CMD_POP_FRONT) begin
            owe(slots[front], ST_OK, 1'b1);
            front = (front + 1) % DEPTH;
            count--;
          end else begin
            owe(slots[(front + count - 1) % DEPTH], ST_OK, 1'b1);
            count--;
          end
        end
        CMD_DUMP: begin
          if (count == 0) begin
            owe('0, ST_EMPTY, 1'b1);
          end else begin
            for (k = 0; k < count; k++)
              owe(slots[(front + k) % DEPTH], ST_OK, (k + 1 == count));
          end
        end
        default: ; // spare command codes: no result
      endcase
    endfunction

    function void check_result(dq_out_t got);
      dq_out_t want;
      if (owed_q.size() == 0) begin
        $display("%0t: result with none owed: value_out %0d status %0d last %0b",
                 $time, got.value_out, got.status, got.last);
        failures++;
        return;
      end
      want = owed_q.pop_front();
      if (got.value_out !== want.value_out) begin
        $display("%0t: value_out expected %0d actual %0d",
                 $time, want.value_out, got.value_out);
        failures++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        failures++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
        failures++;
      end
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction
  endclass

  dq_scoreboard results;

  double_ended_queue #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: take results on unstalled edges, then pick the next stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0)
      results.check_result(out_data_o);
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  task automatic idle_gap();
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
  endtask

  // Valid stays high between back-to-back items; only gaps and drains lower it
  task automatic send_item(input logic [2:0] cmd, input logic signed [31:0] value);
    dq_in_t it;
    it.cmd      = cmd;
    it.value_in = value;
    in_data_i  <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    results.note_item(it);
    idle_gap();
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (results.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(9))
      0:       return 32'sh7FFFFFFF;
      1:       return 32'sh80000000;
      2:       return '0;
      3:       return -32'sh1;
      default: return $signed($urandom);
    endcase
  endfunction

  function automatic logic [2:0] pick_cmd(int push_pct);
    int r;
    r = $urandom_range(99);
    if (r < 3)
      return 3'($urandom_range(CMD_UNUSED_LAST, CMD_UNUSED_FIRST));
    if (r < 12)
      return CMD_DUMP;
    if ($urandom_range(99) < push_pct)
      return $urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
    return $urandom_range(1) ? CMD_POP_FRONT : CMD_POP_BACK;
  endfunction

  // Runs of fill-, drain- or balanced-biased traffic so both full and empty get hit
  task automatic random_phase(int n_items);
    logic [2:0] cmd;
    int         sent;
    int         push_pct;
    int         run_len;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(2))
        0:       push_pct = 80;
        1:       push_pct = 25;
        default: push_pct = 50;
      endcase
      run_len = $urandom_range(16, 6);
      while (run_len > 0 && sent < n_items) begin
        cmd = pick_cmd(push_pct);
        send_item(cmd, rand_value());
        if (cmd <= CMD_DUMP)
          sent++;
        run_len--;
      end
    end
  endtask

  initial begin
    logic signed [31:0] patterns [4];
    int                 k;
    patterns = '{32'sh0, -32'sh1, 32'sh55555555, 32'shAAAAAAAA};
    results  = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty-queue cases
    send_item(CMD_POP_FRONT, 32'sh12345678);
    send_item(CMD_POP_BACK, -32'sh1);
    send_item(CMD_DUMP, '0);
    // lone element removed from either end
    send_item(CMD_PUSH_FRONT, 32'sh7FFFFFFF);
    send_item(CMD_POP_BACK, '0);
    send_item(CMD_PUSH_BACK, 32'sh80000000);
    send_item(CMD_POP_FRONT, '0);
    send_item(CMD_UNUSED_FIRST, -32'sh1);
    send_item(CMD_UNUSED_LAST, '0);
    // fill from both ends so the front index wraps, then overflow and dump
    for (k = 0; k < DEPTH; k++)
      send_item(k[0] ? CMD_PUSH_BACK : CMD_PUSH_FRONT,
                (k < 4) ? patterns[k] : $signed($urandom));
    send_item(CMD_PUSH_FRONT, 32'sh1);
    send_item(CMD_PUSH_BACK, -32'sh2);
    send_item(CMD_DUMP, '0);
    drain();

    idle_pct  = 0;
    stall_pct = 0;
    random_phase(PHASE_ITEMS);
    drain();

    idle_pct  = 70;
    stall_pct = 0;
    random_phase(PHASE_ITEMS);
    drain();

    idle_pct  = 0;
    stall_pct = 70;
    random_phase(PHASE_ITEMS);
    drain();

    idle_pct  = 36;
    stall_pct = 36;
    random_phase(PHASE_ITEMS);
    drain();

    if (results.failures == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== double_ended_queue.f =====
hw/rtl/dq_pkg.sv
hw/rtl/dq_datapath.sv
hw/rtl/dq_ctrl.sv
hw/rtl/double_ended_queue.sv
test/tb_double_ended_queue.sv
